@@ rtl/core/bpc_pkg.sv @@
package bpc_pkg;

  localparam int unsigned MASK_W   = 5;
  localparam int unsigned WORD_W   = 15;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned SLOTS    = WORD_W / SLOT_W;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESS_THRESHOLD   = 2'd0,
    REG_HOLD_THRESHOLD    = 2'd1,
    REG_DOUBLE_GAP        = 2'd2,
    REG_RELEASE_THRESHOLD = 2'd3
  } reg_index_t;

  localparam logic [CFG_W-1:0] PRESS_THRESHOLD_RST   = 8'd4;
  localparam logic [CFG_W-1:0] HOLD_THRESHOLD_RST    = 8'd200;
  localparam logic [CFG_W-1:0] DOUBLE_GAP_RST        = 8'd2;
  localparam logic [CFG_W-1:0] RELEASE_THRESHOLD_RST = 8'd20;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SINGLE = 2'd1,
    ST_HOLD   = 2'd2,
    ST_DOUBLE = 2'd3
  } code_t;

  typedef struct packed {
    logic  released;
    code_t code;
  } status_t;

  typedef struct packed {
    logic [CFG_W-1:0] press_threshold;
    logic [CFG_W-1:0] hold_threshold;
    logic [CFG_W-1:0] double_gap;
    logic [CFG_W-1:0] release_threshold;
  } cfg_t;

  localparam status_t STATUS_IDLE = '{released: 1'b0, code: ST_IDLE};

endpackage

@@ rtl/core/bpc_button.sv @@
module bpc_button (
  input  logic             clk,
  input  logic             rst,
  input  logic             tick,
  input  logic             down,
  input  logic             clear,
  input  bpc_pkg::cfg_t    cfg,
  output bpc_pkg::status_t status_next
);
  import bpc_pkg::*;

  logic [COUNT_W-1:0] press_count;
  logic [COUNT_W-1:0] press_count_next;
  logic [COUNT_W-1:0] release_count;
  logic [COUNT_W-1:0] release_count_next;
  status_t            status;

  always_comb begin
    status_t            st;
    logic [COUNT_W-1:0] pc;
    logic [COUNT_W-1:0] rc;
    st = clear ? STATUS_IDLE : status;
    pc = press_count;
    rc = release_count;
    if (down) begin
      pc = press_count + COUNT_W'(1);
      if (st == status_t'{released: 1'b0, code: ST_SINGLE}) begin
        if (pc == cfg.hold_threshold) begin
          rc = '0;
          st.code = ST_HOLD;
        end
        if (pc == cfg.press_threshold && rc > cfg.double_gap) begin
          rc = '0;
          st.code = ST_DOUBLE;
        end
      end else if (st == STATUS_IDLE) begin
        rc = '0;
        if (pc == cfg.press_threshold) begin
          st.code = ST_SINGLE;
        end
      end
    end else begin
      pc = '0;
      if (st != STATUS_IDLE) begin
        rc = release_count + COUNT_W'(1);
        if (rc == cfg.release_threshold) begin
          st.released = 1'b1;
        end
      end
    end
    press_count_next   = pc;
    release_count_next = rc;
    status_next        = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_count   <= '0;
      release_count <= '0;
      status        <= STATUS_IDLE;
    end else if (tick) begin
      press_count   <= press_count_next;
      release_count <= release_count_next;
      status        <= status_next;
    end
  end

endmodule

@@ rtl/core/button_press_classifier.sv @@
// Channel  Direction  Handshake              Payload
// config   in         cfg_write              cfg_index, cfg_data
// in       in         in_valid / in_ready    pressed_mask, clear_mask
// out      out        out_valid / out_ready  status_word
//
// A beat passes an input register and then the per-button update, which
// writes the button state and the result register in the same cycle.
// Beats are taken at one per cycle while the output is not stalled.
// Reset clears all counters, statuses and valid flags and loads the default
// thresholds. A stalled output holds the input register, which still frees
// itself whenever the result register moves on.
module button_press_classifier #(
  parameter int unsigned BUTTONS = 5
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bpc_pkg::MASK_W-1:0]         pressed_mask,
  input  logic [bpc_pkg::MASK_W-1:0]         clear_mask,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bpc_pkg::WORD_W-1:0]         status_word
);
  import bpc_pkg::*;

  cfg_t              cfg;
  logic              in_full;
  logic [MASK_W-1:0] pressed_r;
  logic [MASK_W-1:0] clear_r;
  logic              advance;
  logic [WORD_W-1:0] status_word_next;
  status_t           status_next [BUTTONS];

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_threshold   <= PRESS_THRESHOLD_RST;
      cfg.hold_threshold    <= HOLD_THRESHOLD_RST;
      cfg.double_gap        <= DOUBLE_GAP_RST;
      cfg.release_threshold <= RELEASE_THRESHOLD_RST;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_PRESS_THRESHOLD:   cfg.press_threshold   <= cfg_data;
        REG_HOLD_THRESHOLD:    cfg.hold_threshold    <= cfg_data;
        REG_DOUBLE_GAP:        cfg.double_gap        <= cfg_data;
        REG_RELEASE_THRESHOLD: cfg.release_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pressed_r <= pressed_mask;
      clear_r   <= clear_mask;
    end
  end

  for (genvar b = 0; b < BUTTONS; b++) begin : g_button
    logic down;
    logic clear;
    if (b < MASK_W) begin : g_masked
      assign down  = pressed_r[b];
      assign clear = clear_r[b];
    end else begin : g_unmasked
      assign down  = 1'b0;
      assign clear = 1'b0;
    end
    bpc_button u_button (
      .clk         (clk),
      .rst         (rst),
      .tick        (advance),
      .down        (down),
      .clear       (clear),
      .cfg         (cfg),
      .status_next (status_next[b])
    );
  end

  // The word is built from the state being written, so it shows each
  // button after the tick.
  for (genvar i = 0; i < SLOTS; i++) begin : g_slot
    if (i < BUTTONS) begin : g_used
      assign status_word_next[SLOT_W*i +: SLOT_W] = status_next[i];
    end else begin : g_empty
      assign status_word_next[SLOT_W*i +: SLOT_W] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status_word <= status_word_next;
    end
  end

endmodule
